// File: hdl/dual_wheel_encoder_odometer_assert.svh
// Assertion macros shared by the odometer RTL.
// Each module that uses them has clk and arst_n in scope.
`ifndef DUAL_WHEEL_ENCODER_ODOMETER_ASSERT_SVH
`define DUAL_WHEEL_ENCODER_ODOMETER_ASSERT_SVH

// same-cycle implication
`define DWEO_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWEO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/dweo_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the dual wheel encoder odometer.
// No dependencies; used by every module of the block.
package dweo_pkg;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_DIST   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b1;

	localparam logic [15:0] PD_RESET      = 16'd5000;
	localparam logic [31:0] TIMEOUT_RESET = 32'd2000000;

	localparam logic FUNC_EDGE   = 1'b0;
	localparam logic FUNC_REPORT = 1'b1;
	localparam logic KIND_EDGE   = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// pulse distance (um) * 1000 fits in 26 bits
	localparam int NUM_W = 26;
	localparam logic [9:0] MM_SCALE = 10'd1000;
	localparam logic [15:0] SPEED_MAX = 16'hFFFF;
	localparam logic [31:0] DIST_MAX  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        func;
		logic        wheel;
		logic        level;
		logic [31:0] now_us;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic        wheel_out;
		logic [15:0] pulse_count;
		logic [31:0] distance_um;
		logic [15:0] speed_mm_s;
		logic        idle_cleared;
	} out_item_t;

	// decoded request handed from front to back
	typedef struct packed {
		logic        is_report;
		logic        wheel;
		logic        pulse;
		logic [31:0] now_us;
	} cmd_t;

	typedef struct packed {
		logic [15:0] pulse_distance_um;
		logic [31:0] idle_timeout_us;
	} cfg_t;

endpackage

// File: hdl/dweo_front.sv
`timescale 1ns / 1ps
// Front end: accepts input requests, decodes them and queues them for the back end.
// Depends on dweo_pkg and the assertion macro header.
`include "dual_wheel_encoder_odometer_assert.svh"
module dweo_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  dweo_pkg::in_item_t item,
	output logic              cmd_valid,
	input  logic              cmd_pop,
	output dweo_pkg::cmd_t    cmd
);
	import dweo_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       entry_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       new_cmd;
	logic       push_ok;
	logic       pop_ok;

	always_comb begin
		new_cmd.is_report = (item.func == FUNC_REPORT);
		new_cmd.wheel     = item.wheel;
		// only a high level on an edge request counts a pulse
		new_cmd.pulse     = (item.func == FUNC_EDGE) && item.level;
		new_cmd.now_us    = item.now_us;
	end

	assign full      = (cnt_q == 2'(DEPTH));
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = entry_q[rd_ptr_q];
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop_ok)
				rd_ptr_q <= ~rd_ptr_q;
			if (push_ok && !pop_ok)
				cnt_q <= cnt_q + 2'd1;
			else if (pop_ok && !push_ok)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok)
			entry_q[wr_ptr_q] <= new_cmd;
	end

	`DWEO_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= 2'd2, "front queue count out of range")
	`DWEO_ASSERT_NEXT(a_pop_drains, pop_ok && !push_ok, cnt_q == $past(cnt_q) - 2'd1, "pop lost")
	`DWEO_ASSERT_NEXT(a_push_fills, push_ok && !pop_ok, cnt_q == $past(cnt_q) + 2'd1, "push lost")

endmodule

// File: hdl/dweo_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the wheel speed.
// Depends on dweo_pkg.
module dweo_div #(
	parameter int DEN_BITS = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dweo_pkg::NUM_W-1:0] num,
	input  logic [DEN_BITS-1:0]        den,
	output logic                       done,
	output logic [dweo_pkg::NUM_W-1:0] quo
);
	import dweo_pkg::*;

	localparam int W     = ((DEN_BITS > NUM_W) ? DEN_BITS : NUM_W) + 1;
	localparam int CNT_W = $clog2(NUM_W);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NUM_W - 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W-1:0]     shifted;
	logic             take;

	assign shifted = {rem_q[W-2:0], quo_q[NUM_W-1]};
	assign take    = (shifted >= den_q);
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= W'(den);
		end else if (busy_q) begin
			rem_q <= take ? (shifted - den_q) : shifted;
			quo_q <= {quo_q[NUM_W-2:0], take};
		end
	end

endmodule

// File: hdl/dweo_exec.sv
`timescale 1ns / 1ps
// Back end: holds the wheel state and carries out edge and report requests.
// Depends on dweo_pkg, dweo_div and the assertion macro header.
`include "dual_wheel_encoder_odometer_assert.svh"
module dweo_exec #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dweo_pkg::cfg_t      cfg,
	input  logic                cmd_valid,
	output logic                cmd_pop,
	input  dweo_pkg::cmd_t      cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output dweo_pkg::out_item_t res
);
	import dweo_pkg::*;

	localparam int SUM_W  = COUNT_BITS + 1;
	localparam int PROD_W = SUM_W + 16;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CALC = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]            state_q;
	cmd_t                  cmd_q;
	logic [COUNT_BITS-1:0] lp_q, rp_q;
	logic [TIME_BITS-1:0]  llast_q, rlast_q;
	logic [15:0]           lspd_q, rspd_q;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [SUM_W-1:0]      sum_q;
	logic [PROD_W-1:0]     prod_q;
	logic                  dt_zero_q;
	logic                  idle_q;
	logic [15:0]           avg_q;

	logic [TIME_BITS+31:0] now_ext;
	logic [TIME_BITS-1:0]  now_t;
	logic [COUNT_BITS-1:0] cur_cnt, cnt_new;
	logic [TIME_BITS-1:0]  cur_last, dt, dt_l, dt_r;
	logic [SUM_W-1:0]      sum, mul_a;
	logic [16:0]           spd_sum;
	logic [TIME_BITS+31:0] dt_l_ext, dt_r_ext, to_ext;
	logic                  idle;
	logic [NUM_W-1:0]      num;
	logic                  div_start, div_done;
	logic [NUM_W-1:0]      quo;

	logic [PROD_W-1:0]     dist_src;
	logic [PROD_W+31:0]    dist_ext;
	logic [SUM_W-1:0]      cnt_src;
	logic [SUM_W+15:0]     cnt_ext;
	logic [15:0]           edge_spd;

	// timestamps are taken modulo 2^TIME_BITS
	assign now_ext  = {{TIME_BITS{1'b0}}, cmd_q.now_us};
	assign now_t    = now_ext[TIME_BITS-1:0];

	assign cur_cnt  = cmd_q.wheel ? rp_q : lp_q;
	assign cur_last = cmd_q.wheel ? rlast_q : llast_q;
	assign cnt_new  = (cmd_q.pulse && cur_cnt != {COUNT_BITS{1'b1}}) ? cur_cnt + 1'b1 : cur_cnt;
	assign dt       = now_t - cur_last;
	assign sum      = {1'b0, lp_q} + {1'b0, rp_q};
	assign mul_a    = cmd_q.is_report ? sum : {1'b0, cnt_new};
	assign spd_sum  = {1'b0, lspd_q} + {1'b0, rspd_q};

	assign dt_l     = now_t - llast_q;
	assign dt_r     = now_t - rlast_q;
	assign dt_l_ext = {32'd0, dt_l};
	assign dt_r_ext = {32'd0, dt_r};
	assign to_ext   = {{TIME_BITS{1'b0}}, cfg.idle_timeout_us};
	assign idle     = (dt_l_ext > to_ext) && (dt_r_ext > to_ext);

	assign num       = NUM_W'(cfg.pulse_distance_um) * NUM_W'(MM_SCALE);
	assign div_start = (state_q == S_CALC) && !cmd_q.is_report;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = (state_q == S_OUT) && res_ready;

	dweo_div #(
		.DEN_BITS(TIME_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (dt),
		.done  (div_done),
		.quo   (quo)
	);

	// saturate distance, count and speed onto the narrow result fields
	assign dist_src = cmd_q.is_report ? (prod_q >> 1) : prod_q;
	assign dist_ext = {32'd0, dist_src};
	assign cnt_src  = cmd_q.is_report ? sum_q : {1'b0, cnt_q};
	assign cnt_ext  = {16'd0, cnt_src};
	assign edge_spd = (dt_zero_q || (|quo[NUM_W-1:16])) ? SPEED_MAX : quo[15:0];

	always_comb begin
		res.kind         = cmd_q.is_report ? KIND_REPORT : KIND_EDGE;
		res.wheel_out    = cmd_q.is_report ? 1'b0 : cmd_q.wheel;
		res.pulse_count  = (|cnt_ext[SUM_W+15:16]) ? 16'hFFFF : cnt_ext[15:0];
		res.distance_um  = (|dist_ext[PROD_W+31:32]) ? DIST_MAX : dist_ext[31:0];
		res.speed_mm_s   = cmd_q.is_report ? avg_q : edge_spd;
		res.idle_cleared = cmd_q.is_report && idle_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lp_q    <= '0;
			rp_q    <= '0;
			llast_q <= '0;
			rlast_q <= '0;
			lspd_q  <= '0;
			rspd_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid)
						state_q <= S_CALC;
				end
				S_CALC: begin
					state_q <= cmd_q.is_report ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
						if (!cmd_q.is_report) begin
							if (cmd_q.wheel) begin
								rp_q    <= cnt_q;
								rlast_q <= now_t;
								rspd_q  <= edge_spd;
							end else begin
								lp_q    <= cnt_q;
								llast_q <= now_t;
								lspd_q  <= edge_spd;
							end
						end else if (idle_q) begin
							// last edge times are kept on an idle clear
							lp_q   <= '0;
							rp_q   <= '0;
							lspd_q <= '0;
							rspd_q <= '0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop)
			cmd_q <= cmd;
		if (state_q == S_CALC) begin
			cnt_q     <= cnt_new;
			sum_q     <= sum;
			prod_q    <= PROD_W'(mul_a) * PROD_W'(cfg.pulse_distance_um);
			dt_zero_q <= (dt == '0);
			idle_q    <= idle;
			avg_q     <= spd_sum[16:1];
		end
	end

	`DWEO_ASSERT_NOW(a_pop_idle, cmd_pop, state_q == S_IDLE, "request taken while busy")
	`DWEO_ASSERT_NEXT(a_div_exit, state_q == S_DIV && div_done, state_q == S_OUT, "divide lost")
	`DWEO_ASSERT_NOW(a_res_slot, res_valid, state_q == S_OUT && res_ready, "result overrun")
	`DWEO_ASSERT_NOW(a_div_quiet, state_q == S_OUT || state_q == S_IDLE, !div_done, "late divide")

endmodule

// File: hdl/dual_wheel_encoder_odometer.sv
`timescale 1ns / 1ps
// Top level of the two-wheel encoder odometer: config registers and result register.
// Depends on dweo_pkg, dweo_front and dweo_exec.
//
// Usage:
//   Input requests enter through push/full as a queue write; item.func selects an
//   encoder edge (wheel, level, now_us) or a report. Results leave through
//   empty/pop; the oldest result sits on result while empty is low.
//   Configuration: cfg_we writes cfg_wdata into register cfg_idx (0 pulse
//   distance in um, 1 idle timeout in us); write only while the block is idle.
// Flow:
//   An edge passes the front queue, the back end's calc state, the 26-step serial
//   divider that forms the speed, and the result register; a report skips the
//   divider. One request is worked on at a time, so the back end takes no new
//   request before the last one leaves. A two-entry front queue keeps accepting
//   while the back end works.
// Reset:
//   arst_n clears counts, speeds and last edge times, and loads 5000 um and
//   2000000 us into the configuration registers. If the receiver holds off
//   pop, the result register stays full, the back end waits with its next
//   result, and full rises once the front queue fills.
module dual_wheel_encoder_odometer #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  dweo_pkg::in_item_t                 item,
	output logic                               empty,
	input  logic                               pop,
	output dweo_pkg::out_item_t                result,
	input  logic                               cfg_we,
	input  logic [dweo_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [31:0]                        cfg_wdata
);
	import dweo_pkg::*;

	cfg_t      cfg_q;
	logic      cmd_valid, cmd_pop;
	cmd_t      cmd;
	logic      res_valid, res_ready;
	out_item_t res;
	out_item_t out_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_distance_um <= PD_RESET;
			cfg_q.idle_timeout_us   <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_PULSE_DIST:   cfg_q.pulse_distance_um <= cfg_wdata[15:0];
				CFG_IDLE_TIMEOUT: cfg_q.idle_timeout_us   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	dweo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd)
	);

	dweo_exec #(
		.COUNT_BITS(COUNT_BITS),
		.TIME_BITS (TIME_BITS)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd_valid(cmd_valid),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// result register refills in the same cycle it is popped
	assign res_ready = !out_valid_q || pop;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_q <= res;
	end

endmodule

// File: test/dweo_checker.sv
`timescale 1ns / 1ps
// Checker for the two-wheel encoder odometer: watches the request, result and
// register write channels, predicts every result and compares. Depends on dweo_pkg.
module dweo_checker #(
	parameter int COUNT_BITS = 16,
	parameter int TIME_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  dweo_pkg::in_item_t             item,
	input  logic                           empty,
	input  logic                           pop,
	input  dweo_pkg::out_item_t            result,
	input  logic                           cfg_we,
	input  logic [dweo_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                    cfg_wdata,
	output int                             fails,
	output int                             pending
);
	import dweo_pkg::*;

	localparam bit [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	bit [15:0]           pulse_dist;
	bit [31:0]           idle_limit;
	bit [COUNT_BITS-1:0] pulses [2];
	bit [TIME_BITS-1:0]  last_edge [2];
	bit [15:0]           wheel_speed [2];

	out_item_t expected_readings [$];

	function automatic out_item_t odometry_update(in_item_t it);
		out_item_t r;
		bit w;
		bit [TIME_BITS-1:0] now_t, dt, idle_l, idle_r;
		bit [63:0] num, quo, cnt64, dist64;
		bit [16:0] spd_sum;
		r = '0;
		now_t = TIME_BITS'(it.now_us);
		if (it.func == FUNC_EDGE) begin
			w = it.wheel;
			if (it.level && pulses[w] != CNT_MAX)
				pulses[w] = pulses[w] + 1'b1;
			dt = now_t - last_edge[w];
			last_edge[w] = now_t;
			num = 64'(pulse_dist) * 64'd1000;
			if (dt == 0) begin
				wheel_speed[w] = SPEED_MAX;
			end else begin
				quo = num / 64'(dt);
				wheel_speed[w] = (quo > 64'(SPEED_MAX)) ? SPEED_MAX : quo[15:0];
			end
			cnt64 = 64'(pulses[w]);
			dist64 = cnt64 * 64'(pulse_dist);
			r.kind = KIND_EDGE;
			r.wheel_out = w;
			r.speed_mm_s = wheel_speed[w];
		end else begin
			cnt64 = 64'(pulses[0]) + 64'(pulses[1]);
			dist64 = (cnt64 * 64'(pulse_dist)) >> 1;
			spd_sum = 17'(wheel_speed[0]) + 17'(wheel_speed[1]);
			idle_l = now_t - last_edge[0];
			idle_r = now_t - last_edge[1];
			r.kind = KIND_REPORT;
			r.speed_mm_s = spd_sum[16:1];
			r.idle_cleared = (64'(idle_l) > 64'(idle_limit)) && (64'(idle_r) > 64'(idle_limit));
			// values go out from before the clear
			if (r.idle_cleared) begin
				pulses[0] = '0;
				pulses[1] = '0;
				wheel_speed[0] = '0;
				wheel_speed[1] = '0;
			end
		end
		r.pulse_count = (cnt64 > 64'hFFFF) ? 16'hFFFF : cnt64[15:0];
		r.distance_um = (dist64 > 64'(DIST_MAX)) ? DIST_MAX : dist64[31:0];
		return r;
	endfunction

	task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fails++;
			if (fails <= 10)
				$display("%0t: %s mismatch, expected %0d got %0d", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pulse_dist = PD_RESET;
			idle_limit = TIMEOUT_RESET;
			pulses = '{default: '0};
			last_edge = '{default: '0};
			wheel_speed = '{default: '0};
			expected_readings.delete();
			fails = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_PULSE_DIST:   pulse_dist = cfg_wdata[15:0];
					CFG_IDLE_TIMEOUT: idle_limit = cfg_wdata;
					default: ;
				endcase
			end
			if (push && !full)
				expected_readings.push_back(odometry_update(item));
			if (pop && !empty) begin
				if (expected_readings.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with no request outstanding: %p", $realtime, result);
				end else begin
					want = expected_readings.pop_front();
					note_field("kind", 32'(want.kind), 32'(result.kind));
					note_field("wheel_out", 32'(want.wheel_out), 32'(result.wheel_out));
					note_field("pulse_count", 32'(want.pulse_count), 32'(result.pulse_count));
					note_field("distance_um", want.distance_um, result.distance_um);
					note_field("speed_mm_s", 32'(want.speed_mm_s), 32'(result.speed_mm_s));
					note_field("idle_cleared", 32'(want.idle_cleared), 32'(result.idle_cleared));
				end
			end
			pending <= expected_readings.size();
		end
	end

endmodule

// File: test/tb_dual_wheel_encoder_odometer.sv
`timescale 1ns / 1ps
// Testbench top for the two-wheel encoder odometer: clock, reset, request and
// register stimulus, verdict. Depends on dweo_pkg, dual_wheel_encoder_odometer, dweo_checker.
module tb_dual_wheel_encoder_odometer;
	import dweo_pkg::*;

	localparam int COUNT_BITS = 16;
	localparam int TIME_BITS  = 32;
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	in_item_t             item = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	out_item_t            result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = CFG_PULSE_DIST;
	logic [31:0]          cfg_wdata = '0;

	int fails;
	int pending;
	int sent = 0;
	int cycles = 0;
	bit gaps_on = 1'b1;

	// stimulus-side view of time, used to aim reports at the idle boundary
	bit [31:0] cur_timeout = TIMEOUT_RESET;
	bit [31:0] clock_us = '0;
	bit [31:0] sent_last [2] = '{default: '0};
	bit        pin [2] = '{default: 1'b0};

	dual_wheel_encoder_odometer #(
		.COUNT_BITS(COUNT_BITS),
		.TIME_BITS (TIME_BITS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	dweo_checker #(
		.COUNT_BITS(COUNT_BITS),
		.TIME_BITS (TIME_BITS)
	) CHK (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.fails    (fails),
		.pending  (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic in_item_t mk(logic func, logic wheel, logic level, logic [31:0] now_us);
		in_item_t it;
		it.func = func;
		it.wheel = wheel;
		it.level = level;
		it.now_us = now_us;
		return it;
	endfunction

	task automatic send_request(in_item_t it);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		sent++;
	endtask

	task automatic drain;
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// pulse distance gets random upper bits, which the block must drop
	task automatic set_config(logic [15:0] pd, logic [31:0] tmo);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_PULSE_DIST;
		cfg_wdata <= {16'($urandom), pd};
		@(posedge clk);
		cfg_idx <= CFG_IDLE_TIMEOUT;
		cfg_wdata <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_timeout = tmo;
	endtask

	task automatic drive_traffic(int n);
		in_item_t it;
		int sel;
		bit w;
		repeat (n) begin
			sel = $urandom_range(0, 99);
			w = 1'($urandom_range(0, 1));
			if (sel < 15) begin
				it = mk(FUNC_REPORT, 1'($urandom), 1'($urandom), clock_us);
				case ($urandom_range(0, 3))
					0: it.now_us = sent_last[w] + cur_timeout - 32'd1 + 32'($urandom_range(0, 2));
					1: it.now_us = $urandom;
					default: it.now_us = clock_us + 32'($urandom_range(0, 3000));
				endcase
			end else begin
				// mostly a running encoder: time moves forward, levels alternate
				sel = $urandom_range(0, 99);
				if (sel < 60)
					clock_us = clock_us + 32'($urandom_range(1, 2000));
				else if (sel < 80)
					clock_us = clock_us + 32'($urandom_range(2000, 5000000));
				else if (sel < 88)
					clock_us = clock_us - 32'($urandom_range(1, 1000));
				else if (sel < 95)
					clock_us = $urandom;
				if ($urandom_range(0, 6) != 0)
					pin[w] = ~pin[w];
				sent_last[w] = clock_us;
				it = mk(FUNC_EDGE, w, pin[w], clock_us);
			end
			send_request(it);
		end
	endtask

	// result side: random stalls, one long hold to back the block up
	initial begin
		bit held;
		held = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held && sent >= 100) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (600) @(posedge clk);
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// report before any edge: measured from time 0, then at and past the timeout
		send_request(mk(FUNC_REPORT, 1'b0, 1'b0, 32'd0));
		send_request(mk(FUNC_REPORT, 1'b1, 1'b1, 32'd2000000));
		send_request(mk(FUNC_REPORT, 1'b0, 1'b1, 32'd2000001));
		send_request(mk(FUNC_EDGE, 1'b0, 1'b1, 32'd100));
		send_request(mk(FUNC_EDGE, 1'b0, 1'b1, 32'd100));        // zero interval
		send_request(mk(FUNC_EDGE, 1'b0, 1'b0, 32'd150));        // short interval saturates
		send_request(mk(FUNC_EDGE, 1'b1, 1'b1, 32'd1000000));
		send_request(mk(FUNC_EDGE, 1'b1, 1'b0, 32'hFFFF_FFFF));
		send_request(mk(FUNC_EDGE, 1'b0, 1'b1, 32'hFFFF_FFFF));
		send_request(mk(FUNC_EDGE, 1'b1, 1'b1, 32'd3));          // wraps forward
		send_request(mk(FUNC_EDGE, 1'b0, 1'b1, 32'd100));
		send_request(mk(FUNC_REPORT, 1'b1, 1'b0, 32'd50));
		send_request(mk(FUNC_EDGE, 1'b0, 1'b1, 32'd20));         // earlier than last edge
		send_request(mk(FUNC_EDGE, 1'b1, 1'b1, 32'd25));
		send_request(mk(FUNC_REPORT, 1'b0, 1'b0, 32'd2000020));  // left at limit, right under it
		send_request(mk(FUNC_REPORT, 1'b0, 1'b0, 32'd2000026));  // both idle: clears
		send_request(mk(FUNC_REPORT, 1'b1, 1'b1, 32'd2000026));
		send_request(mk(FUNC_EDGE, 1'b1, 1'b1, 32'h8000_0000));
		send_request(mk(FUNC_EDGE, 1'b0, 1'b0, 32'h8000_0001));
		send_request(mk(FUNC_REPORT, 1'b0, 1'b0, 32'h8000_0000 + 32'd2000001));
		clock_us = 32'h8000_0001;
		sent_last = '{32'h8000_0001, 32'h8000_0000};

		drive_traffic(200);

		drain();
		set_config(16'd1, 32'd1);
		drive_traffic(150);

		drain();
		set_config(16'hFFFF, 32'hFFFF_FFFF);
		drive_traffic(150);

		drain();
		set_config(16'($urandom_range(1, 65535)), 32'($urandom_range(1, 20000)));
		drive_traffic(150);

		drain();
		set_config(PD_RESET, TIMEOUT_RESET);
		gaps_on = 1'b0;
		drive_traffic(200);

		drain();
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
